// ===== hdl/gcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcfp_pkg - shared types for the glyph column framebuffer packer
// Operation and register codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package gcfp_pkg;

  localparam int ROWS_MAX  = 32;                 // row buffer depth at double size
  localparam int CNT_W     = $clog2(ROWS_MAX);   // row / byte counter width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 3;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_COLUMN = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION_Y = 2'd0,
    REG_DOUBLE_SIZE = 2'd1,
    REG_START_X     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_X_COL,
    ST_FLUSH,
    ST_Y_MAIN,
    ST_Y_CARRY
  } state_t;

  typedef struct packed {
    logic load_in;     // capture the accepted item
    logic clear_all;   // clear rows, column, carry and group count
    logic clear_rows;  // clear row buffer only
    logic begin_load;  // load start column for a new X run
    logic x_apply;     // OR the column into the row buffer, step the column
    logic cnt_clear;
    logic cnt_inc;
    logic emit_row;    // send row_buffer[cnt]
    logic emit_main;   // send shifted Y byte
    logic emit_carry;  // send trailing carry byte
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic direction_y;
    logic pc_zero;
    logic pc_wrap;        // column step completes a byte
    logic row_last;
    logic y_last;         // last Y byte of this column
    logic carry_follows;  // current Y byte closes a group
    logic out_free;       // output register can take a byte
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/gcfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcfp_ctrl - sequencer for the glyph column framebuffer packer
// Decodes each item and steps the datapath through transpose, flush or Y path.
// ----------------------------------------------------------------------------
`default_nettype none

module gcfp_ctrl
  import gcfp_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status.op)
          OP_BEGIN: begin
            cmd.clear_all  = 1'b1;
            cmd.begin_load = 1'b1;
            state_next     = ST_IDLE;
          end
          OP_COLUMN: begin
            cmd.cnt_clear = 1'b1;
            state_next    = status.direction_y ? ST_Y_MAIN : ST_X_COL;
          end
          OP_FINISH: begin
            if (!status.direction_y && !status.pc_zero) begin
              cmd.cnt_clear = 1'b1;
              state_next    = ST_FLUSH;
            end else begin
              cmd.clear_all = 1'b1;
              state_next    = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;   // unused code: no effect
          end
        endcase
      end
      ST_X_COL: begin
        cmd.x_apply = 1'b1;
        if (status.pc_wrap) begin
          cmd.cnt_clear = 1'b1;
          state_next    = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_row = 1'b1;
          cmd.cnt_inc  = 1'b1;
          if (status.row_last) begin
            if (status.op == OP_FINISH) begin
              cmd.clear_all = 1'b1;
            end else begin
              cmd.clear_rows = 1'b1;
            end
            state_next = ST_IDLE;
          end
        end
      end
      ST_Y_MAIN: begin
        if (status.out_free) begin
          cmd.emit_main = 1'b1;
          if (status.carry_follows) begin
            state_next = ST_Y_CARRY;
          end else if (status.y_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_Y_CARRY: begin
        if (status.out_free) begin
          cmd.emit_carry = 1'b1;
          if (status.y_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = ST_Y_MAIN;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gcfp_datapath.sv =====
// ----------------------------------------------------------------------------
// gcfp_datapath - row buffer, Y shifter and output register
// Holds configuration, run state and the byte waiting on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module gcfp_datapath
  import gcfp_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_valid,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DAT_W-1:0]  cfg_data,
  input  wire [1:0]            in_op,
  input  wire [7:0]            in_first,
  input  wire [7:0]            in_second,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic direction_y, double_size;
  logic [2:0] start_x;

  op_t        op_q;
  logic [7:0] first_q, second_q;

  logic [7:0]       row_buffer [ROWS_MAX];
  logic [2:0]       pixel_column;
  logic [7:0]       carry_bits;
  logic [2:0]       group_count;
  logic [CNT_W-1:0] cnt;

  function automatic logic [7:0] widen_nibble(input logic [3:0] nib);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[2*k]   = nib[k];
      r[2*k+1] = nib[k];
    end
    return r;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      direction_y <= 1'b1;
      double_size <= 1'b0;
      start_x     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIRECTION_Y: direction_y <= cfg_data[0];
        REG_DOUBLE_SIZE: double_size <= cfg_data[0];
        REG_START_X:     start_x     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q     <= op_t'(in_op);
      first_q  <= in_first;
      second_q <= in_second;
    end
  end

  // X transpose: per-row set masks for the current column
  logic [2:0]  col_base, pc_next;
  logic [7:0]  col_bit, pair_bits;
  logic [7:0]  set_mask [ROWS_MAX];

  assign col_base  = {pixel_column[2:1], 1'b0};
  assign col_bit   = 8'd1 << (3'd7 - pixel_column);
  assign pair_bits = 8'd3 << (3'd6 - col_base);
  assign pc_next   = double_size ? 3'(col_base + 3'd2) : 3'(pixel_column + 3'd1);

  always_comb begin
    for (int r = 0; r < ROWS_MAX; r++) begin
      set_mask[r] = '0;
    end
    if (!double_size) begin
      for (int c = 0; c < 8; c++) begin
        set_mask[c]   = second_q[7-c] ? col_bit : 8'd0;
        set_mask[8+c] = first_q[7-c]  ? col_bit : 8'd0;
      end
    end else begin
      for (int c = 0; c < 8; c++) begin
        set_mask[2*c]    = second_q[7-c] ? pair_bits : 8'd0;
        set_mask[2*c+1]  = second_q[7-c] ? pair_bits : 8'd0;
        set_mask[16+2*c] = first_q[7-c]  ? pair_bits : 8'd0;
        set_mask[17+2*c] = first_q[7-c]  ? pair_bits : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS_MAX; r++) begin
      if (rst || cmd.clear_all || cmd.clear_rows) begin
        row_buffer[r] <= '0;
      end else if (cmd.x_apply) begin
        row_buffer[r] <= row_buffer[r] | set_mask[r];
      end
    end
  end

  // Y path: byte select, shift and group carry
  logic [7:0] y_byte, y_main;
  logic [2:0] gc_inc, group_size;
  logic       carry_follows;

  always_comb begin
    if (!double_size) begin
      y_byte = cnt[0] ? second_q : first_q;
    end else begin
      unique case (cnt[1:0])
        2'd0:    y_byte = widen_nibble(first_q[7:4]);
        2'd1:    y_byte = widen_nibble(first_q[3:0]);
        2'd2:    y_byte = widen_nibble(second_q[7:4]);
        default: y_byte = widen_nibble(second_q[3:0]);
      endcase
    end
  end

  assign y_main        = (start_x == 3'd0) ? y_byte : (carry_bits | (y_byte >> start_x));
  assign gc_inc        = 3'(group_count + 3'd1);
  assign group_size    = double_size ? 3'd4 : 3'd2;
  assign carry_follows = (start_x != 3'd0) && (gc_inc >= group_size);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      pixel_column <= '0;
      carry_bits   <= '0;
      group_count  <= '0;
      if (!rst && cmd.begin_load && !direction_y) begin
        pixel_column <= double_size ? {start_x[2:1], 1'b0} : start_x;
      end
    end else begin
      if (cmd.x_apply) begin
        pixel_column <= pc_next;
      end
      if (cmd.emit_main && start_x != 3'd0) begin
        carry_bits  <= 8'(y_byte << (4'd8 - {1'b0, start_x}));
        group_count <= carry_follows ? 3'd0 : gc_inc;
      end
      if (cmd.emit_carry) begin
        carry_bits <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= CNT_W'(cnt + 1'b1);
    end
  end

  // output register
  logic row_last, y_last, out_free;

  assign row_last = (cnt == (double_size ? CNT_W'(ROWS_MAX - 1) : CNT_W'(ROWS_MAX / 2 - 1)));
  assign y_last   = double_size ? (cnt[2:0] == 3'd7) : (cnt[2:0] == 3'd1);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_row || cmd.emit_main || cmd.emit_carry) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_row) begin
      out_byte <= row_buffer[cnt];
      out_last <= row_last;
    end else if (cmd.emit_main) begin
      out_byte <= y_main;
      out_last <= y_last && !carry_follows;
    end else if (cmd.emit_carry) begin
      out_byte <= carry_bits;
      out_last <= y_last;
    end
  end

  always_comb begin
    status.op            = op_q;
    status.direction_y   = direction_y;
    status.pc_zero       = (pixel_column == 3'd0);
    status.pc_wrap       = (pc_next == 3'd0);
    status.row_last      = row_last;
    status.y_last        = y_last;
    status.carry_follows = carry_follows;
    status.out_free      = out_free;
  end

`ifndef SYNTHESIS
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_row, cmd.emit_main, cmd.emit_carry}))
    else $error("more than one output source selected");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_row || cmd.emit_main || cmd.emit_carry) |-> out_free)
    else $error("output byte overwritten before transfer");

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    group_count < 3'd4)
    else $error("group count past largest group");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_all |=> (carry_bits == 8'd0) && (group_count == 3'd0))
    else $error("run state not cleared");
`endif

endmodule

`default_nettype wire

// ===== hdl/glyph_column_framebuffer_packer_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_column_framebuffer_packer_unit - glyph columns to framebuffer bytes
// Transposes or shifts 16-pixel glyph columns into display bytes.
// ----------------------------------------------------------------------------
// One item is handled at a time. It is accepted in the idle state and
// decoded in the dispatch state; after that each output byte waits in the
// output register while the sink is not ready. A begin or a finish without
// flush ends in the dispatch state, and an X column that does not complete
// a byte ends after its X column state. After decoding, a Y column sends 2
// to 3 bytes at normal size, or 8 to 10 at double size. An X column that
// completes eight pixel columns, and a finish with a partial byte, drain
// the row buffer one row a cycle while the sink is ready: 16 rows, or 32
// at double size. The row buffer is cleared all at once, so no sweep follows
// reset. tlast marks the final byte caused by an item. Configuration writes
// are always taken (cfg_ready is high) and must only be made between items.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_column_framebuffer_packer_unit
  import gcfp_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  // slave side: glyph column items
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [15:0]           s_axis_tdata,   // [7:0] column_first, [15:8] column_second
  input  wire [1:0]            s_axis_tuser,   // [1:0] operation
  // master side: framebuffer bytes
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
  output logic                 m_axis_tlast,   // last_of_run
  // register writes
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,      // 0 direction_y, 1 double_size, 2 start_x
  input  wire [CFG_DAT_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  // writes apply at once; the user keeps the block idle when they arrive, unchecked
  assign cfg_ready = 1'b1;

  gcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gcfp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_axis_tuser),
    .in_first  (s_axis_tdata[7:0]),
    .in_second (s_axis_tdata[15:8]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire
